// ===== sv/urb_pkg.sv =====
// ----------------------------------------------------------------------------
// urb_pkg
// shared types, constants and the Q30 product used by the unit-ray pipeline
// ----------------------------------------------------------------------------
package urb_pkg;

  localparam int WORK_BITS = 30;
  localparam int QW        = WORK_BITS + 1;
  localparam int RAD_W     = 2 * QW;
  localparam int NUM_W     = QW + WORK_BITS;

  typedef struct packed {
    logic signed [23:0] x_coord;
    logic signed [23:0] y_coord;
  } in_beat_t;

  typedef struct packed {
    logic signed [23:0] ray_x;
    logic signed [23:0] ray_y;
    logic        [22:0] ray_z;
    logic signed [23:0] dxdx;
    logic signed [23:0] dxdy;
    logic signed [23:0] dydx;
    logic signed [23:0] dydy;
    logic signed [23:0] dzdx;
    logic signed [23:0] dzdy;
  } out_beat_t;

  // rounded Q30 product, p may carry one extra integer bit
  function automatic logic [QW:0] qmul(logic [QW:0] p, logic [QW-1:0] q);
    logic [2*QW:0] prod;
    prod = (2*QW+1)'(p) * (2*QW+1)'(q) + ((2*QW+1)'(1) << (WORK_BITS - 1));
    return prod[WORK_BITS+QW:WORK_BITS];
  endfunction

endpackage

// ===== sv/urb_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// urb_sqrt_pipe
// floor square root, one result bit per pipeline stage, with sideband data
// ----------------------------------------------------------------------------
module urb_sqrt_pipe #(
  parameter int SB_W = 95
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [urb_pkg::RAD_W-1:0] rad_i,
  input  logic [SB_W-1:0]           sb_i,
  output logic                      valid_o,
  output logic [urb_pkg::QW-1:0]    root_o,
  output logic [SB_W-1:0]           sb_o
);
  import urb_pkg::*;

  localparam int NS = QW;

  logic [RAD_W-1:0] v_q   [NS];
  logic [RAD_W-1:0] res_q [NS];
  logic [SB_W-1:0]  sb_q  [NS];
  logic [NS-1:0]    vld_q;

  logic [RAD_W-1:0] v_in   [NS];
  logic [RAD_W-1:0] res_in [NS];
  logic [SB_W-1:0]  sb_in  [NS];
  logic [NS-1:0]    vld_in;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    localparam logic [RAD_W-1:0] BitVal = RAD_W'(1) << (2 * (NS - 1 - g));
    logic [RAD_W-1:0] trial;
    logic [RAD_W-1:0] v_d;
    logic [RAD_W-1:0] res_d;

    if (g == 0) begin : g_first
      assign v_in[g]   = rad_i;
      assign res_in[g] = '0;
      assign sb_in[g]  = sb_i;
      assign vld_in[g] = valid_i;
    end else begin : g_next
      assign v_in[g]   = v_q[g-1];
      assign res_in[g] = res_q[g-1];
      assign sb_in[g]  = sb_q[g-1];
      assign vld_in[g] = vld_q[g-1];
    end

    always_comb begin
      trial = res_in[g] + BitVal;
      if (v_in[g] >= trial) begin
        v_d   = v_in[g] - trial;
        res_d = (res_in[g] >> 1) + BitVal;
      end else begin
        v_d   = v_in[g];
        res_d = res_in[g] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[g]   <= v_d;
        res_q[g] <= res_d;
        sb_q[g]  <= sb_in[g];
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = res_q[NS-1][QW-1:0];
  assign sb_o    = sb_q[NS-1];

endmodule

// ===== sv/urb_div_pipe.sv =====
// ----------------------------------------------------------------------------
// urb_div_pipe
// three-lane restoring divider sharing one divisor, one quotient bit per stage
// ----------------------------------------------------------------------------
module urb_div_pipe #(
  parameter int SB_W = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [2:0][urb_pkg::NUM_W-1:0] num_i,
  input  logic [urb_pkg::QW-1:0]         den_i,
  input  logic [SB_W-1:0]                sb_i,
  output logic                           valid_o,
  output logic [2:0][urb_pkg::QW-1:0]    quot_o,
  output logic [SB_W-1:0]                sb_o
);
  import urb_pkg::*;

  localparam int NS = QW;

  logic [2:0][QW-1:0] rem_q [NS];
  logic [2:0][QW-1:0] lo_q  [NS];
  logic [2:0][QW-1:0] quo_q [NS];
  logic [QW-1:0]      den_q [NS];
  logic [SB_W-1:0]    sb_q  [NS];
  logic [NS-1:0]      vld_q;

  logic [2:0][QW-1:0] rem_in [NS];
  logic [2:0][QW-1:0] lo_in  [NS];
  logic [2:0][QW-1:0] quo_in [NS];
  logic [QW-1:0]      den_in [NS];
  logic [SB_W-1:0]    sb_in  [NS];
  logic [NS-1:0]      vld_in;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [2:0][QW-1:0] rem_d;
    logic [2:0][QW-1:0] lo_d;
    logic [2:0][QW-1:0] quo_d;

    if (g == 0) begin : g_first
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[g][l] = QW'(num_i[l][NUM_W-1:QW]);
        assign lo_in[g][l]  = num_i[l][QW-1:0];
        assign quo_in[g][l] = '0;
      end
      assign den_in[g] = den_i;
      assign sb_in[g]  = sb_i;
      assign vld_in[g] = valid_i;
    end else begin : g_next
      assign rem_in[g] = rem_q[g-1];
      assign lo_in[g]  = lo_q[g-1];
      assign quo_in[g] = quo_q[g-1];
      assign den_in[g] = den_q[g-1];
      assign sb_in[g]  = sb_q[g-1];
      assign vld_in[g] = vld_q[g-1];
    end

    always_comb begin
      logic [QW:0] trial;
      for (int l = 0; l < 3; l++) begin
        trial = {rem_in[g][l], lo_in[g][l][QW-1]};
        lo_d[l] = lo_in[g][l] << 1;
        if (trial >= {1'b0, den_in[g]}) begin
          rem_d[l] = QW'(trial - {1'b0, den_in[g]});
          quo_d[l] = {quo_in[g][l][QW-2:0], 1'b1};
        end else begin
          rem_d[l] = trial[QW-1:0];
          quo_d[l] = {quo_in[g][l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= rem_d;
        lo_q[g]  <= lo_d;
        quo_q[g] <= quo_d;
        den_q[g] <= den_in[g];
        sb_q[g]  <= sb_in[g];
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quot_o  = quo_q[NS-1];
  assign sb_o    = sb_q[NS-1];

endmodule

// ===== sv/unit_ray_backprojection_top.sv =====
// ----------------------------------------------------------------------------
// unit_ray_backprojection_top
// unit camera ray and its 3x2 jacobian from a normalized image point
// ----------------------------------------------------------------------------
// Fully pipelined: one point enters per clock while the pipe advances, and it
// passes through four normalize/square stages, a 31-stage square root, one
// setup stage, a 31-stage three-lane divider, three product/pack stages and
// the output register. The whole pipe advances together whenever the output
// register is empty or being taken, so throughput is one beat per cycle while
// the sink keeps up; latency is set by the bit-serial root and divider stages.
module unit_ray_backprojection_top #(
  parameter int IN_FRAC_BITS  = 20,
  parameter int OUT_FRAC_BITS = 22
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  urb_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output urb_pkg::out_beat_t out_data_o
);
  import urb_pkg::*;

  localparam int InSh   = (IN_FRAC_BITS > WORK_BITS) ? IN_FRAC_BITS - WORK_BITS : 0;
  localparam int InRnd  = (1 << InSh) >> 1;
  localparam int CExp   = (IN_FRAC_BITS > WORK_BITS) ? WORK_BITS : IN_FRAC_BITS;
  localparam logic [QW-1:0] CVal = QW'(1) << CExp;
  localparam logic [QW-1:0] OneW = QW'(1) << WORK_BITS;
  localparam int ShR    = (OUT_FRAC_BITS < WORK_BITS) ? WORK_BITS - OUT_FRAC_BITS : 0;
  localparam int ShL    = (OUT_FRAC_BITS > WORK_BITS) ? OUT_FRAC_BITS - WORK_BITS : 0;
  localparam int RndInc = (1 << ShR) >> 1;
  localparam int OmW    = QW + 2 + ShL;
  localparam int SqSbW  = 3 * QW + 2;

  function automatic logic [23:0] pack_mag(logic [QW:0] v, logic neg);
    logic [OmW-1:0] w;
    logic [23:0]    m;
    w = ((OmW'(v) + OmW'(RndInc)) >> ShR) << ShL;
    if (w == '0) begin
      return '0;
    end
    if (neg) begin
      m = (w > OmW'(24'h800000)) ? 24'h800000 : w[23:0];
      return ~m + 24'd1;
    end
    return (w > OmW'(24'h7fffff)) ? 24'h7fffff : w[23:0];
  endfunction

  logic en;
  logic out_valid_q;
  out_beat_t out_data_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // stage 1: magnitudes and common maximum
  logic          s1_vld_q, s1_na_q, s1_nb_q;
  logic [23:0]   s1_a_q, s1_b_q;
  logic [QW-1:0] s1_m_q;
  logic [23:0]   mag_x, mag_y, s1_a_d, s1_b_d;
  logic [QW-1:0] s1_m_d;

  always_comb begin
    mag_x  = in_data_i.x_coord[23] ? ~in_data_i.x_coord + 24'd1 : in_data_i.x_coord;
    mag_y  = in_data_i.y_coord[23] ? ~in_data_i.y_coord + 24'd1 : in_data_i.y_coord;
    s1_a_d = 24'((25'(mag_x) + 25'(InRnd)) >> InSh);
    s1_b_d = 24'((25'(mag_y) + 25'(InRnd)) >> InSh);
    s1_m_d = CVal;
    if (QW'(s1_a_d) > s1_m_d) begin
      s1_m_d = QW'(s1_a_d);
    end
    if (QW'(s1_b_d) > s1_m_d) begin
      s1_m_d = QW'(s1_b_d);
    end
  end

  // stage 2: normalize so the largest lies in (2^29, 2^30]
  logic          s2_vld_q, s2_na_q, s2_nb_q;
  logic [QW-1:0] s2_a_q, s2_b_q, s2_c_q;
  logic [QW-1:0] mm1;
  logic [4:0]    bl, sh_k;

  always_comb begin
    mm1 = s1_m_q - QW'(1);
    bl  = '0;
    for (int i = 0; i < QW; i++) begin
      if (mm1[i]) begin
        bl = 5'(i + 1);
      end
    end
    sh_k = 5'(WORK_BITS) - bl;
  end

  // stage 3: squares, stage 4: radicand
  logic             s3_vld_q, s3_na_q, s3_nb_q;
  logic [QW-1:0]    s3_a_q, s3_b_q, s3_c_q;
  logic [RAD_W-1:0] s3_aa_q, s3_bb_q, s3_cc_q;
  logic             s4_vld_q;
  logic [RAD_W-1:0] s4_rad_q;
  logic [SqSbW-1:0] s4_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_a_q   <= s1_a_d;
      s1_b_q   <= s1_b_d;
      s1_m_q   <= s1_m_d;
      s1_na_q  <= in_data_i.x_coord[23];
      s1_nb_q  <= in_data_i.y_coord[23];
      s2_a_q   <= QW'(s1_a_q) << sh_k;
      s2_b_q   <= QW'(s1_b_q) << sh_k;
      s2_c_q   <= CVal << sh_k;
      s2_na_q  <= s1_na_q;
      s2_nb_q  <= s1_nb_q;
      s3_aa_q  <= RAD_W'(s2_a_q) * RAD_W'(s2_a_q);
      s3_bb_q  <= RAD_W'(s2_b_q) * RAD_W'(s2_b_q);
      s3_cc_q  <= RAD_W'(s2_c_q) * RAD_W'(s2_c_q);
      s3_a_q   <= s2_a_q;
      s3_b_q   <= s2_b_q;
      s3_c_q   <= s2_c_q;
      s3_na_q  <= s2_na_q;
      s3_nb_q  <= s2_nb_q;
      s4_rad_q <= s3_aa_q + s3_bb_q + s3_cc_q;
      s4_sb_q  <= {s3_a_q, s3_b_q, s3_c_q, s3_na_q, s3_nb_q};
    end
  end

  // square root
  logic             sq_vld;
  logic [QW-1:0]    sq_root;
  logic [SqSbW-1:0] sq_sb;

  urb_sqrt_pipe #(
    .SB_W (SqSbW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_vld_q),
    .rad_i   (s4_rad_q),
    .sb_i    (s4_sb_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .sb_o    (sq_sb)
  );

  // stage 5: rounded dividends
  logic                   s5_vld_q;
  logic [2:0][NUM_W-1:0]  s5_num_q;
  logic [QW-1:0]          s5_den_q;
  logic [1:0]             s5_sg_q;
  logic [QW-1:0]          rt;
  logic [2:0][QW-1:0]     nmag;

  always_comb begin
    rt      = (sq_root == '0) ? QW'(1) : sq_root;
    nmag[0] = sq_sb[SqSbW-1 -: QW];
    nmag[1] = sq_sb[SqSbW-1-QW -: QW];
    nmag[2] = sq_sb[SqSbW-1-2*QW -: QW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        s5_num_q[l] <= (NUM_W'(nmag[l]) << WORK_BITS) + NUM_W'(rt >> 1);
      end
      s5_den_q <= rt;
      s5_sg_q  <= sq_sb[1:0];
    end
  end

  // division
  logic               dv_vld;
  logic [2:0][QW-1:0] dv_quot;
  logic [1:0]         dv_sg;

  urb_div_pipe #(
    .SB_W (2)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_vld_q),
    .num_i   (s5_num_q),
    .den_i   (s5_den_q),
    .sb_i    (s5_sg_q),
    .valid_o (dv_vld),
    .quot_o  (dv_quot),
    .sb_o    (dv_sg)
  );

  // stage 6: clamp unit ray, stage 7: first products, stage 8: jacobian
  logic          s6_vld_q, s6_na_q, s6_nb_q;
  logic [QW-1:0] s6_rx_q, s6_ry_q, s6_rz_q;
  logic          s7_vld_q, s7_na_q, s7_nb_q;
  logic [QW-1:0] s7_rx_q, s7_ry_q, s7_rz_q;
  logic [QW:0]   s7_xx_q, s7_yy_q, s7_zz_q, s7_xy_q;
  logic          s8_vld_q, s8_na_q, s8_nb_q;
  logic [QW-1:0] s8_rx_q, s8_ry_q, s8_rz_q;
  logic [QW:0]   s8_jxx_q, s8_jyy_q, s8_jxy_q, s8_jzx_q, s8_jzy_q;
  logic [QW-1:0] zz_n;

  assign zz_n = s7_zz_q[QW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q    <= 1'b0;
      s7_vld_q    <= 1'b0;
      s8_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s6_vld_q    <= dv_vld;
      s7_vld_q    <= s6_vld_q;
      s8_vld_q    <= s7_vld_q;
      out_valid_q <= s8_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_rx_q  <= (dv_quot[0] > OneW) ? OneW : dv_quot[0];
      s6_ry_q  <= (dv_quot[1] > OneW) ? OneW : dv_quot[1];
      s6_rz_q  <= (dv_quot[2] > OneW) ? OneW : dv_quot[2];
      s6_na_q  <= dv_sg[1];
      s6_nb_q  <= dv_sg[0];
      s7_xx_q  <= qmul({1'b0, s6_rx_q}, s6_rx_q);
      s7_yy_q  <= qmul({1'b0, s6_ry_q}, s6_ry_q);
      s7_zz_q  <= qmul({1'b0, s6_rz_q}, s6_rz_q);
      s7_xy_q  <= qmul({1'b0, s6_rx_q}, s6_ry_q);
      s7_rx_q  <= s6_rx_q;
      s7_ry_q  <= s6_ry_q;
      s7_rz_q  <= s6_rz_q;
      s7_na_q  <= s6_na_q;
      s7_nb_q  <= s6_nb_q;
      s8_jxx_q <= qmul(s7_yy_q + s7_zz_q, s7_rz_q);
      s8_jyy_q <= qmul(s7_xx_q + s7_zz_q, s7_rz_q);
      s8_jxy_q <= qmul(s7_xy_q, s7_rz_q);
      s8_jzx_q <= qmul({1'b0, s7_rx_q}, zz_n);
      s8_jzy_q <= qmul({1'b0, s7_ry_q}, zz_n);
      s8_rx_q  <= s7_rx_q;
      s8_ry_q  <= s7_ry_q;
      s8_rz_q  <= s7_rz_q;
      s8_na_q  <= s7_na_q;
      s8_nb_q  <= s7_nb_q;
      out_data_q.ray_x <= pack_mag({1'b0, s8_rx_q}, s8_na_q);
      out_data_q.ray_y <= pack_mag({1'b0, s8_ry_q}, s8_nb_q);
      out_data_q.ray_z <= 23'(pack_mag({1'b0, s8_rz_q}, 1'b0));
      out_data_q.dxdx  <= pack_mag(s8_jxx_q, 1'b0);
      out_data_q.dxdy  <= pack_mag(s8_jxy_q, s8_na_q == s8_nb_q);
      out_data_q.dydx  <= pack_mag(s8_jxy_q, s8_na_q == s8_nb_q);
      out_data_q.dydy  <= pack_mag(s8_jyy_q, 1'b0);
      out_data_q.dzdx  <= pack_mag(s8_jzx_q, !s8_na_q);
      out_data_q.dzdy  <= pack_mag(s8_jzy_q, !s8_nb_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  a_sym_jac : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.dxdy == out_data_o.dydx)
    else $error("jacobian off-diagonal terms differ");

  a_diag_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_data_o.dxdx[23] && !out_data_o.dydy[23])
    else $error("jacobian diagonal negative");

  a_dz_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.ray_x != '0 && out_data_o.dzdx != '0
      |-> out_data_o.ray_x[23] != out_data_o.dzdx[23])
    else $error("dzdx sign does not oppose ray_x");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// checks the unit-ray pipeline against a bit-exact fixed-point predictor,
// with random idle bursts on the input side and stalls on the output side
// ----------------------------------------------------------------------------
module tb_top;
  import urb_pkg::*;

  localparam int IN_FB  = 20;
  localparam int OUT_FB = 22;
  localparam int WB     = 30;
  localparam longint unsigned ONE_Q = 64'd1 << WB;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_data_o;

  out_beat_t ray_q[$];
  int        n_bad = 0;
  bit        calm = 1'b0;

  unit_ray_backprojection_top #(.IN_FRAC_BITS(IN_FB), .OUT_FRAC_BITS(OUT_FB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mulq(longint unsigned p, longint unsigned q);
    return (p * q + (ONE_Q >> 1)) >> WB;
  endfunction

  function automatic longint unsigned unit_of(longint unsigned m, longint unsigned r);
    longint unsigned v;
    v = (m * ONE_Q + (r >> 1)) / r;
    return (v > ONE_Q) ? ONE_Q : v;
  endfunction

  function automatic longint unsigned out_mag(longint unsigned v);
    if (OUT_FB < WB) return (v + (64'd1 << (WB - OUT_FB - 1))) >> (WB - OUT_FB);
    return v << (OUT_FB - WB);
  endfunction

  function automatic logic [23:0] to_signed(longint unsigned v, bit neg);
    longint unsigned m;
    m = out_mag(v);
    if (m == 0) return '0;
    if (neg) begin
      if (m > 64'h800000) m = 64'h800000;
      return 24'((64'h1000000 - m) & 64'hFFFFFF);
    end
    if (m > 64'h7FFFFF) m = 64'h7FFFFF;
    return 24'(m);
  endfunction

  function automatic out_beat_t predict_ray(in_beat_t pt);
    out_beat_t o;
    longint unsigned a, b, c, m, r, rx, ry, rz, t;
    bit na, nb;
    na = pt.x_coord[23];
    nb = pt.y_coord[23];
    a = na ? 64'h1000000 - 64'(pt.x_coord[23:0]) : 64'(pt.x_coord[23:0]);
    b = nb ? 64'h1000000 - 64'(pt.y_coord[23:0]) : 64'(pt.y_coord[23:0]);
    c = 64'd1 << IN_FB;
    m = c;
    if (a > m) m = a;
    if (b > m) m = b;
    while ((m << 1) <= ONE_Q) begin
      m <<= 1; a <<= 1; b <<= 1; c <<= 1;
    end
    r = isqrt(a * a + b * b + c * c);
    if (r == 0) r = 1;
    rx = unit_of(a, r);
    ry = unit_of(b, r);
    rz = unit_of(c, r);
    o.ray_x = to_signed(rx, na);
    o.ray_y = to_signed(ry, nb);
    t = out_mag(rz);
    o.ray_z = (t > 64'h7FFFFF) ? 23'h7FFFFF : 23'(t);
    o.dxdx = to_signed(mulq(mulq(ry, ry) + mulq(rz, rz), rz), 1'b0);
    o.dxdy = to_signed(mulq(mulq(rx, ry), rz), na == nb);
    o.dydx = o.dxdy;
    o.dydy = to_signed(mulq(mulq(rx, rx) + mulq(rz, rz), rz), 1'b0);
    t = mulq(rz, rz);
    o.dzdx = to_signed(mulq(rx, t), !na);
    o.dzdy = to_signed(mulq(ry, t), !nb);
    return o;
  endfunction

  task automatic send_point(logic [23:0] x, logic [23:0] y);
    in_beat_t pt;
    int gap;
    if (!calm && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pt.x_coord = x;
    pt.y_coord = y;
    in_valid_i <= 1'b1;
    in_data_i  <= pt;
    ray_q.push_back(predict_ray(pt));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stall bursts on the result side
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(3) == 0) begin
        n = $urandom_range(1, 5);
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      n = $urandom_range(1, 8);
      repeat (n) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    out_beat_t exp_b;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (ray_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected beat %h", out_data_o);
      end else begin
        exp_b = ray_q.pop_front();
        if (exp_b !== out_data_o) begin
          n_bad++;
          if (n_bad <= 10) $display("mismatch exp %h got %h", exp_b, out_data_o);
        end
      end
    end
  end

  task automatic test_extremes();
    logic [23:0] v[8] = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'h100000,
                          24'hF00000, 24'h000001, 24'hFFFFFF, 24'h555555};
    foreach (v[i]) send_point(v[i], v[(i * 3 + 1) % 8]);
    send_point(24'h800000, 24'h800000);
    send_point(24'h7FFFFF, 24'h7FFFFF);
    send_point(24'h000000, 24'h000000);
    send_point(24'h7FFFFF, 24'h800000);
  endtask

  task automatic test_random(int n);
    logic [23:0] x, y;
    repeat (n) begin
      case ($urandom_range(3))
        0: begin x = 24'($urandom); y = 24'($urandom); end
        1: begin // near the optical axis
          x = 24'($signed($urandom_range(0, 8191)) - 4096);
          y = 24'($signed($urandom_range(0, 8191)) - 4096);
        end
        2: begin
          x = 24'($signed($urandom_range(0, 4194303)) - 2097152);
          y = 24'($urandom);
        end
        default: begin
          x = 24'($urandom);
          y = 24'($signed($urandom_range(0, 2097151)) - 1048576);
        end
      endcase
      send_point(x, y);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_random(800);
    calm = 1'b1;
    test_random(200);
    in_valid_i <= 1'b0;
    while (ray_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (n_bad == 0) $display("unit_ray_backprojection_top test passed");
    else $display("unit_ray_backprojection_top test failed");
    $finish;
  end

  initial begin
    #200000;
    $display("unit_ray_backprojection_top test failed");
    $finish;
  end

endmodule
